>>> rtl/core/dbgpio_pkg.sv
// Package for the dual-bank GPIO block: register map, op codes and the
// transaction payload types. No dependencies.
package dbgpio_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ADDR_W = 7;
	localparam int unsigned PIN_W  = 5;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_PIN   = 2'd2;

	localparam logic [ADDR_W-1:0] ADDR_DATA_A = 7'd0;
	localparam logic [ADDR_W-1:0] ADDR_DIR_A  = 7'd1;
	localparam logic [ADDR_W-1:0] ADDR_DATA_B = 7'd2;
	localparam logic [ADDR_W-1:0] ADDR_DIR_B  = 7'd3;
	localparam logic [ADDR_W-1:0] ADDR_GIE    = 7'd71;
	localparam logic [ADDR_W-1:0] ADDR_STATUS = 7'd72;
	localparam logic [ADDR_W-1:0] ADDR_ENABLE = 7'd74;

	localparam int unsigned GIE_BIT = 31;

	localparam logic [WORD_W-1:0] STATUS_A_MASK = 32'h0000_0001;
	localparam logic [WORD_W-1:0] STATUS_B_MASK = 32'h0000_0002;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] word_addr;
		logic [WORD_W-1:0] write_data;
		logic              bank;
		logic [PIN_W-1:0]  pin_index;
		logic              pin_level;
	} dbgpio_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              irq;
		logic [WORD_W-1:0] out_pins_a;
		logic [WORD_W-1:0] out_pins_b;
	} dbgpio_rsp_t;

endpackage

>>> rtl/core/dbgpio_req_if.sv
// Request channel: valid/ready handshake carrying one bus or pin-event transaction.
// Depends on dbgpio_pkg.
interface dbgpio_req_if;
	import dbgpio_pkg::*;

	logic        valid;
	logic        ready;
	dbgpio_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/dbgpio_rsp_if.sv
// Response channel: valid/ready handshake carrying one result transaction.
// Depends on dbgpio_pkg.
interface dbgpio_rsp_if;
	import dbgpio_pkg::*;

	logic        valid;
	logic        ready;
	dbgpio_rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/dbgpio_core.sv
// Register file and update logic of both GPIO banks; computes the result of one
// transaction and commits the new state on commit. Depends on dbgpio_pkg.
module dbgpio_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     commit,
	input  dbgpio_pkg::dbgpio_req_t  req,
	output dbgpio_pkg::dbgpio_rsp_t  rsp
);
	import dbgpio_pkg::*;

	logic [WORD_W-1:0] data_a_q, dir_a_q, data_b_q, dir_b_q;
	logic [WORD_W-1:0] gie_q, status_q, enable_q, drive_a_q, drive_b_q;
	logic [WORD_W-1:0] data_a_d, dir_a_d, data_b_d, dir_b_d;
	logic [WORD_W-1:0] gie_d, status_d, enable_d, drive_a_d, drive_b_d;
	logic [WORD_W-1:0] rd;
	logic [WORD_W-1:0] pin_mask;

	always_comb begin
		data_a_d  = data_a_q;
		dir_a_d   = dir_a_q;
		data_b_d  = data_b_q;
		dir_b_d   = dir_b_q;
		gie_d     = gie_q;
		status_d  = status_q;
		enable_d  = enable_q;
		drive_a_d = drive_a_q;
		drive_b_d = drive_b_q;
		rd        = '0;
		pin_mask  = WORD_W'(1) << req.pin_index;

		unique case (req.op)
			OP_READ: begin
				unique case (req.word_addr)
					ADDR_DATA_A: rd = data_a_q & dir_a_q;
					ADDR_DIR_A:  rd = dir_a_q;
					ADDR_DATA_B: rd = data_b_q & dir_b_q;
					ADDR_DIR_B:  rd = dir_b_q;
					ADDR_GIE:    rd = gie_q;
					ADDR_STATUS: rd = status_q;
					ADDR_ENABLE: rd = enable_q;
					default:     rd = '0;
				endcase
			end
			OP_WRITE: begin
				unique case (req.word_addr)
					ADDR_DATA_A: begin
						data_a_d  = req.write_data;
						drive_a_d = (drive_a_q & dir_a_q) | (req.write_data & ~dir_a_q);
					end
					ADDR_DIR_A: dir_a_d = req.write_data;
					ADDR_DATA_B: begin
						data_b_d  = req.write_data;
						drive_b_d = (drive_b_q & dir_b_q) | (req.write_data & ~dir_b_q);
					end
					ADDR_DIR_B:  dir_b_d  = req.write_data;
					ADDR_GIE:    gie_d    = req.write_data;
					ADDR_STATUS: status_d = req.write_data;
					ADDR_ENABLE: enable_d = req.write_data;
					default: ;
				endcase
			end
			OP_PIN: begin
				if (!req.bank) begin
					if ((dir_a_q & pin_mask) != '0 &&
					    ((data_a_q & pin_mask) != '0) != req.pin_level) begin
						data_a_d = req.pin_level ? (data_a_q | pin_mask) : (data_a_q & ~pin_mask);
						status_d = status_q | STATUS_A_MASK;
					end
				end else begin
					if ((dir_b_q & pin_mask) != '0 &&
					    ((data_b_q & pin_mask) != '0) != req.pin_level) begin
						data_b_d = req.pin_level ? (data_b_q | pin_mask) : (data_b_q & ~pin_mask);
						status_d = status_q | STATUS_B_MASK;
					end
				end
			end
			default: ;
		endcase

		rsp.read_data  = rd;
		rsp.irq        = gie_d[GIE_BIT] && ((status_d & enable_d) != '0);
		rsp.out_pins_a = drive_a_d;
		rsp.out_pins_b = drive_b_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_a_q  <= '0;
			dir_a_q   <= '0;
			data_b_q  <= '0;
			dir_b_q   <= '0;
			gie_q     <= '0;
			status_q  <= '0;
			enable_q  <= '0;
			drive_a_q <= '0;
			drive_b_q <= '0;
		end else if (commit) begin
			data_a_q  <= data_a_d;
			dir_a_q   <= dir_a_d;
			data_b_q  <= data_b_d;
			dir_b_q   <= dir_b_d;
			gie_q     <= gie_d;
			status_q  <= status_d;
			enable_q  <= enable_d;
			drive_a_q <= drive_a_d;
			drive_b_q <= drive_b_d;
		end
	end

`ifndef SYNTHESIS
	// drive words move only on a bus write
	a_drive_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(commit && req.op == OP_WRITE) |=> $stable(drive_a_q) && $stable(drive_b_q))
		else $error("drive word changed without a bus write");

	// upper status bits are never set by pin events
	a_status_hi_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(commit && req.op == OP_WRITE) |=> $stable(status_q[WORD_W-1:2]))
		else $error("status upper bits changed without a bus write");

	// a pin event flips at most one data bit over both banks
	a_pin_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		commit && req.op == OP_PIN |=>
			$countones({data_a_q ^ $past(data_a_q), data_b_q ^ $past(data_b_q)}) <= 1)
		else $error("pin event changed more than one data bit");

	// pin events never touch direction
	a_pin_keeps_dir: assert property (@(posedge clk) disable iff (!arst_n)
		commit && req.op == OP_PIN |=> $stable(dir_a_q) && $stable(dir_b_q))
		else $error("pin event changed a direction word");
`endif

endmodule

>>> rtl/core/dual_bank_gpio_with_interrupt_top.sv
// Top level of the dual-bank GPIO block with interrupt: input register, shared
// register file and output register. Depends on dbgpio_pkg, dbgpio_req_if,
// dbgpio_rsp_if and dbgpio_core.
//
// One transaction in, one result out, at a sustained rate of one per cycle while out_ch.ready stays high.
// A transaction is held in the input register while the register file evaluates
// it; then the result and the new register state are captured together at the
// same edge, in the output register and the register file respectively.
// Back-to-back transactions see the state left by the one before. in_ch.ready
// falls only when both the input and output registers are full and out_ch.ready
// is low. Register file and valid flags reset to zero; data registers do not.
module dual_bank_gpio_with_interrupt_top (
	input  logic         clk,
	input  logic         arst_n,
	dbgpio_req_if.sink   in_ch,
	dbgpio_rsp_if.source out_ch
);
	import dbgpio_pkg::*;

	logic        valid_s1;
	dbgpio_req_t req_s1;
	logic        valid_s2;
	dbgpio_rsp_t rsp_s2;
	dbgpio_rsp_t rsp;
	logic        adv;

	assign adv         = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	dbgpio_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv),
		.req    (req_s1),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			req_s1 <= in_ch.payload;
		end
		if (adv) begin
			rsp_s2 <= rsp;
		end
	end

	assign out_ch.valid   = valid_s2;
	assign out_ch.payload = rsp_s2;

`ifndef SYNTHESIS
	// non-read transactions always return zero read data
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1.op != OP_READ |=> out_ch.payload.read_data == '0)
		else $error("read data nonzero for a non-read transaction");

	// a full input register with a stalled output blocks new transactions
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ch.ready |-> !in_ch.ready)
		else $error("accepted a transaction with both stages full");

	// a result is loaded whenever the input stage drains into a free output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("input stage did not drain into free output register");
`endif

endmodule
